### hw/rtl/bhal_pkg.sv
// Shared types, constants and codes for the boundary-tag heap allocator.
// Used by every module of the allocator; depends on nothing else.
`timescale 1ns / 1ps

package bhal_pkg;

    // Capacity and field widths.
    localparam int unsigned HeapWordsDefault = 16384;
    localparam int unsigned CapLimit         = 16384;
    localparam int unsigned CalcW            = 18;
    localparam int unsigned TagW             = 17;
    localparam int unsigned SizeW            = 17;
    localparam int unsigned AddrW            = 16;

    localparam logic [SizeW-1:0] MinSplitReset = 17'd32;
    localparam logic [SizeW-1:0] MinSplitFloor = 17'd8;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,
        ALU_ADD1 = 2'd1,
        ALU_SUB  = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [CalcW-1:0] a;
        logic [CalcW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [CalcW-1:0] res;
        logic             lt;
        logic             zero;
    } t_alu_rsp;

    typedef struct packed {
        logic             valid;
        logic [AddrW-1:0] addr;
        t_status          status;
    } t_result;

    typedef enum logic [5:0] {
        S_IDLE,
        S_A_INIT, S_A_CHK, S_A_TAG, S_A_NXT, S_A_CMP, S_A_FIT, S_A_SPL,
        S_A_SP0, S_A_SP1, S_A_SP2, S_A_SP3, S_A_SP4,
        S_A_WH0, S_A_WH1, S_A_RES,
        S_A_APP0, S_A_APP1, S_A_APP2, S_A_APP3,
        S_F_INIT, S_F_CHK, S_F_TAG, S_F_NXT, S_F_CMP, S_F_EQ, S_F_BEG,
        S_F_PV0, S_F_PV1, S_F_PV2, S_F_PV3, S_F_PV4, S_F_PV5,
        S_F_NX0, S_F_NX1, S_F_NX2, S_F_NX3, S_F_NX4, S_F_NX5, S_F_NX6, S_F_NX7,
        S_F_WR0, S_F_WR1, S_F_IGN
    } t_state;

endpackage

### hw/rtl/boundary_tag_heap_allocator_core.sv
// Top level of the boundary-tag heap allocator: configuration register, result
// registers, and the sequencer, shared ALU and heap store. Depends on bhal_pkg.
`timescale 1ns / 1ps

// A request is taken when start is high while busy is low, and busy then stays
// high until the request is finished. The result appears on o_payload_addr and
// o_status for exactly one cycle with o_strobe high; the receiver cannot hold it
// off. The time a request takes is set by the number of block tags the first-fit
// walk reads: one read of the single-port heap store per block, with the shared
// adder used once per cycle. After a setup step, an allocate walks past each used
// block and each free block that is too small, then finishes (out of memory,
// append, whole block or split). A free walks each block up to and including the
// one it releases, then finishes, merging with a free neighbour on each side where
// there is one; an ignored free ends as soon as its check fails. Busy drops in the
// cycle the result is shown, so a new request may follow at once. The heap store
// needs no clearing pass, so the block is ready right after reset. The split
// threshold may be written at any time busy is low.

module boundary_tag_heap_allocator_core #(
    parameter int unsigned HEAP_WORDS = bhal_pkg::HeapWordsDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [bhal_pkg::SizeW-1:0] i_alloc_size,
    input  logic [bhal_pkg::AddrW-1:0] i_free_addr,
    output logic                       o_strobe,
    output logic [bhal_pkg::AddrW-1:0] o_payload_addr,
    output logic [1:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bhal_pkg::SizeW-1:0] i_cfg_data
);

    localparam int unsigned CAP_WORDS = (HEAP_WORDS < bhal_pkg::CapLimit) ? HEAP_WORDS
                                                                           : bhal_pkg::CapLimit;
    localparam int unsigned ADDR_W    = $clog2(CAP_WORDS);
    localparam int unsigned TOP_W     = $clog2(CAP_WORDS + 1);

    logic [bhal_pkg::SizeW-1:0] r_min_split;
    logic                       r_strobe;
    logic [bhal_pkg::AddrW-1:0] r_payload_addr;
    bhal_pkg::t_status          r_status;

    bhal_pkg::t_result          result;
    bhal_pkg::t_alu_req         alu_req;
    bhal_pkg::t_alu_rsp         alu_rsp;
    logic                       mem_rd, mem_wr;
    logic [ADDR_W-1:0]          mem_addr;
    logic [bhal_pkg::TagW-1:0]  mem_wdata, mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_split <= bhal_pkg::MinSplitReset;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_split <= i_cfg_data;
            end
            r_strobe <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_payload_addr <= result.addr;
            r_status       <= result.status;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_payload_addr = r_payload_addr;
    assign o_status       = r_status;

    bhal_seq #(
        .CAP_WORDS (CAP_WORDS),
        .ADDR_W    (ADDR_W),
        .TOP_W     (TOP_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req_type   (i_req_type),
        .i_alloc_size (i_alloc_size),
        .i_free_addr  (i_free_addr),
        .i_min_split  (r_min_split),
        .o_busy       (busy),
        .o_result     (result),
        .o_alu_req    (alu_req),
        .i_alu_rsp    (alu_rsp),
        .o_mem_rd     (mem_rd),
        .o_mem_wr     (mem_wr),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .i_mem_rdata  (mem_rdata)
    );

    bhal_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    bhal_mem #(
        .DEPTH  (CAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd),
        .i_wr_en   (mem_wr),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wdata),
        .o_rd_data (mem_rdata)
    );

    // A result only follows a cycle in which a request was in progress.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a request in progress");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Failed allocations and ignored frees report a zero address.
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != bhal_pkg::ST_DONE) |-> (o_payload_addr == '0))
        else $error("nonzero address on a failed request");

    // Granted payload addresses are word aligned.
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_payload_addr[1:0] == 2'b00))
        else $error("payload address not word aligned");

endmodule

### hw/rtl/bhal_alu.sv
// Shared adder/comparator used by the allocator sequencer.
// Depends on bhal_pkg for the request and response types.
`timescale 1ns / 1ps

module bhal_alu (
    input  bhal_pkg::t_alu_req i_req,
    output bhal_pkg::t_alu_rsp o_rsp
);

    logic [bhal_pkg::CalcW-1:0] b_eff;
    logic                       cin;
    logic [bhal_pkg::CalcW:0]   sum;

    always_comb begin
        unique case (i_req.op)
            bhal_pkg::ALU_ADD: begin
                b_eff = i_req.b;
                cin   = 1'b0;
            end
            bhal_pkg::ALU_ADD1: begin
                b_eff = i_req.b;
                cin   = 1'b1;
            end
            bhal_pkg::ALU_SUB: begin
                b_eff = ~i_req.b;
                cin   = 1'b1;
            end
            default: begin
                b_eff = i_req.b;
                cin   = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, i_req.a} + {1'b0, b_eff} + {{bhal_pkg::CalcW{1'b0}}, cin};

    // A subtraction with no carry out means a < b.
    assign o_rsp.res  = sum[bhal_pkg::CalcW-1:0];
    assign o_rsp.lt   = (i_req.op == bhal_pkg::ALU_SUB) && !sum[bhal_pkg::CalcW];
    assign o_rsp.zero = (sum[bhal_pkg::CalcW-1:0] == '0);

endmodule

### hw/rtl/bhal_mem.sv
// Single-port heap word store with registered read data.
// Depends on bhal_pkg for the tag width.
`timescale 1ns / 1ps

module bhal_mem #(
    parameter int unsigned DEPTH  = bhal_pkg::HeapWordsDefault,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [bhal_pkg::TagW-1:0] i_wr_data,
    output logic [bhal_pkg::TagW-1:0] o_rd_data
);

    logic [bhal_pkg::TagW-1:0] r_mem [DEPTH];
    logic [bhal_pkg::TagW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/bhal_seq.sv
// Sequencer for allocate and free requests: walks block tags and rewrites them,
// driving the shared ALU and the heap store. Depends on bhal_pkg.
`timescale 1ns / 1ps

module bhal_seq #(
    parameter int unsigned CAP_WORDS = bhal_pkg::CapLimit,
    parameter int unsigned ADDR_W    = $clog2(CAP_WORDS),
    parameter int unsigned TOP_W     = $clog2(CAP_WORDS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_req_type,
    input  logic [bhal_pkg::SizeW-1:0]  i_alloc_size,
    input  logic [bhal_pkg::AddrW-1:0]  i_free_addr,
    input  logic [bhal_pkg::SizeW-1:0]  i_min_split,
    output logic                        o_busy,
    output bhal_pkg::t_result           o_result,
    output bhal_pkg::t_alu_req          o_alu_req,
    input  bhal_pkg::t_alu_rsp          i_alu_rsp,
    output logic                        o_mem_rd,
    output logic                        o_mem_wr,
    output logic [ADDR_W-1:0]           o_mem_addr,
    output logic [bhal_pkg::TagW-1:0]   o_mem_wdata,
    input  logic [bhal_pkg::TagW-1:0]   i_mem_rdata
);

    localparam int unsigned CW = bhal_pkg::CalcW;
    localparam int unsigned TW = bhal_pkg::TagW;
    localparam logic [CW-1:0] CapCalc = CW'(CAP_WORDS);

    bhal_pkg::t_state r_state, n_state;
    logic [TOP_W-1:0] r_top;

    logic [CW-1:0] r_cur, r_nxt, r_p, r_q, r_h, r_start, r_end, r_size, r_sz, r_left;
    logic          r_bad;

    logic          used;
    logic [CW-1:0] bsw, bs, top_c, ms;
    logic [TW-1:0] sz_tag, bs_tag;
    logic [CW-1:0] res;
    logic          lt, zero;

    assign used   = i_mem_rdata[0];
    assign bsw    = CW'(i_mem_rdata[TW-1:2]);
    assign bs     = CW'({i_mem_rdata[TW-1:2], 2'b00});
    assign sz_tag = {r_sz[TW-1:2], 2'b01};
    assign bs_tag = {i_mem_rdata[TW-1:2], 2'b01};
    assign top_c  = CW'(r_top);
    assign ms     = (i_min_split < bhal_pkg::MinSplitFloor) ? CW'(bhal_pkg::MinSplitFloor)
                                                             : CW'(i_min_split);
    assign res    = i_alu_rsp.res;
    assign lt     = i_alu_rsp.lt;
    assign zero   = i_alu_rsp.zero;

    assign o_busy = (r_state != bhal_pkg::S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhal_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_req_type == bhal_pkg::REQ_FREE) ? bhal_pkg::S_F_INIT
                                                                  : bhal_pkg::S_A_INIT;
                end
            end
            bhal_pkg::S_A_INIT: n_state = bhal_pkg::S_A_CHK;
            bhal_pkg::S_A_CHK:  n_state = lt ? bhal_pkg::S_A_TAG : bhal_pkg::S_A_APP0;
            bhal_pkg::S_A_TAG:  n_state = bhal_pkg::S_A_NXT;
            bhal_pkg::S_A_NXT:  n_state = bhal_pkg::S_A_CMP;
            bhal_pkg::S_A_CMP: begin
                if (lt) begin
                    n_state = bhal_pkg::S_A_APP0;
                end else if (used) begin
                    n_state = bhal_pkg::S_A_CHK;
                end else begin
                    n_state = bhal_pkg::S_A_FIT;
                end
            end
            bhal_pkg::S_A_FIT:  n_state = lt ? bhal_pkg::S_A_CHK : bhal_pkg::S_A_SPL;
            bhal_pkg::S_A_SPL:  n_state = lt ? bhal_pkg::S_A_WH0 : bhal_pkg::S_A_SP0;
            bhal_pkg::S_A_SP0:  n_state = bhal_pkg::S_A_SP1;
            bhal_pkg::S_A_SP1:  n_state = bhal_pkg::S_A_SP2;
            bhal_pkg::S_A_SP2:  n_state = bhal_pkg::S_A_SP3;
            bhal_pkg::S_A_SP3:  n_state = bhal_pkg::S_A_SP4;
            bhal_pkg::S_A_SP4:  n_state = bhal_pkg::S_A_RES;
            bhal_pkg::S_A_WH0:  n_state = bhal_pkg::S_A_WH1;
            bhal_pkg::S_A_WH1:  n_state = bhal_pkg::S_A_RES;
            bhal_pkg::S_A_RES:  n_state = bhal_pkg::S_IDLE;
            bhal_pkg::S_A_APP0: n_state = bhal_pkg::S_A_APP1;
            bhal_pkg::S_A_APP1: n_state = lt ? bhal_pkg::S_A_APP2 : bhal_pkg::S_IDLE;
            bhal_pkg::S_A_APP2: n_state = bhal_pkg::S_A_APP3;
            bhal_pkg::S_A_APP3: n_state = bhal_pkg::S_IDLE;
            bhal_pkg::S_F_INIT: n_state = r_bad ? bhal_pkg::S_F_IGN : bhal_pkg::S_F_CHK;
            bhal_pkg::S_F_CHK:  n_state = lt ? bhal_pkg::S_F_TAG : bhal_pkg::S_F_IGN;
            bhal_pkg::S_F_TAG:  n_state = bhal_pkg::S_F_NXT;
            bhal_pkg::S_F_NXT:  n_state = bhal_pkg::S_F_CMP;
            bhal_pkg::S_F_CMP:  n_state = lt ? bhal_pkg::S_F_IGN : bhal_pkg::S_F_EQ;
            bhal_pkg::S_F_EQ: begin
                if (zero) begin
                    n_state = used ? bhal_pkg::S_F_BEG : bhal_pkg::S_F_IGN;
                end else if (!lt) begin
                    n_state = bhal_pkg::S_F_IGN;
                end else begin
                    n_state = bhal_pkg::S_F_CHK;
                end
            end
            bhal_pkg::S_F_BEG:  n_state = (r_h != '0) ? bhal_pkg::S_F_PV0 : bhal_pkg::S_F_NX0;
            bhal_pkg::S_F_PV0:  n_state = bhal_pkg::S_F_PV1;
            bhal_pkg::S_F_PV1:  n_state = bhal_pkg::S_F_PV2;
            bhal_pkg::S_F_PV2:  n_state = (lt || used) ? bhal_pkg::S_F_NX0 : bhal_pkg::S_F_PV3;
            bhal_pkg::S_F_PV3:  n_state = lt ? bhal_pkg::S_F_NX0 : bhal_pkg::S_F_PV4;
            bhal_pkg::S_F_PV4:  n_state = bhal_pkg::S_F_PV5;
            bhal_pkg::S_F_PV5:  n_state = bhal_pkg::S_F_NX0;
            bhal_pkg::S_F_NX0:  n_state = bhal_pkg::S_F_NX1;
            bhal_pkg::S_F_NX1:  n_state = lt ? bhal_pkg::S_F_NX2 : bhal_pkg::S_F_WR0;
            bhal_pkg::S_F_NX2:  n_state = bhal_pkg::S_F_NX3;
            bhal_pkg::S_F_NX3:  n_state = bhal_pkg::S_F_NX4;
            bhal_pkg::S_F_NX4:  n_state = bhal_pkg::S_F_NX5;
            bhal_pkg::S_F_NX5:  n_state = (lt && !used) ? bhal_pkg::S_F_NX6 : bhal_pkg::S_F_WR0;
            bhal_pkg::S_F_NX6:  n_state = bhal_pkg::S_F_NX7;
            bhal_pkg::S_F_NX7:  n_state = bhal_pkg::S_F_WR0;
            bhal_pkg::S_F_WR0:  n_state = bhal_pkg::S_F_WR1;
            bhal_pkg::S_F_WR1:  n_state = bhal_pkg::S_IDLE;
            bhal_pkg::S_F_IGN:  n_state = bhal_pkg::S_IDLE;
            default:            n_state = bhal_pkg::S_IDLE;
        endcase
    end

    // ALU operands, store accesses and result per state.
    always_comb begin
        o_alu_req   = '{op: bhal_pkg::ALU_ADD, a: '0, b: '0};
        o_mem_rd    = 1'b0;
        o_mem_wr    = 1'b0;
        o_mem_addr  = r_cur[ADDR_W-1:0];
        o_mem_wdata = '0;
        o_result    = '{valid: 1'b0, addr: '0, status: bhal_pkg::ST_DONE};
        unique case (r_state)
            bhal_pkg::S_A_INIT: o_alu_req = '{bhal_pkg::ALU_ADD, r_sz, CW'(3)};
            bhal_pkg::S_A_CHK, bhal_pkg::S_F_CHK: begin
                o_alu_req = '{bhal_pkg::ALU_SUB, r_cur, top_c};
                o_mem_rd  = lt;
            end
            bhal_pkg::S_A_TAG, bhal_pkg::S_F_TAG:
                o_alu_req = '{bhal_pkg::ALU_ADD, r_cur, CW'(2)};
            bhal_pkg::S_A_NXT, bhal_pkg::S_F_NXT:
                o_alu_req = '{bhal_pkg::ALU_ADD, r_nxt, bsw};
            bhal_pkg::S_A_CMP, bhal_pkg::S_F_CMP:
                o_alu_req = '{bhal_pkg::ALU_SUB, top_c, r_nxt};
            bhal_pkg::S_A_FIT:  o_alu_req = '{bhal_pkg::ALU_SUB, bs, r_sz};
            bhal_pkg::S_A_SPL:  o_alu_req = '{bhal_pkg::ALU_SUB, r_left, ms};
            bhal_pkg::S_A_SP0: begin
                o_alu_req   = '{bhal_pkg::ALU_ADD1, r_cur, {2'b00, r_sz[CW-1:2]}};
                o_mem_wr    = 1'b1;
                o_mem_wdata = sz_tag;
            end
            bhal_pkg::S_A_SP1: begin
                o_alu_req   = '{bhal_pkg::ALU_ADD1, r_p, '0};
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_p[ADDR_W-1:0];
                o_mem_wdata = sz_tag;
            end
            bhal_pkg::S_A_SP2:  o_alu_req = '{bhal_pkg::ALU_SUB, r_left, CW'(8)};
            bhal_pkg::S_A_SP3: begin
                o_alu_req   = '{bhal_pkg::ALU_SUB, r_nxt, CW'(1)};
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_p[ADDR_W-1:0];
                o_mem_wdata = r_left[TW-1:0];
            end
            bhal_pkg::S_A_SP4: begin
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_p[ADDR_W-1:0];
                o_mem_wdata = r_left[TW-1:0];
            end
            bhal_pkg::S_A_WH0: begin
                o_alu_req   = '{bhal_pkg::ALU_SUB, r_nxt, CW'(1)};
                o_mem_wr    = 1'b1;
                o_mem_wdata = bs_tag;
            end
            bhal_pkg::S_A_WH1: begin
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_p[ADDR_W-1:0];
                o_mem_wdata = bs_tag;
            end
            bhal_pkg::S_A_RES: begin
                o_alu_req = '{bhal_pkg::ALU_ADD1, r_cur, '0};
                o_result  = '{1'b1, {res[bhal_pkg::AddrW-3:0], 2'b00}, bhal_pkg::ST_DONE};
            end
            bhal_pkg::S_A_APP0:
                o_alu_req = '{bhal_pkg::ALU_ADD1, top_c, {2'b00, r_sz[CW-1:2]}};
            bhal_pkg::S_A_APP1: begin
                o_alu_req = '{bhal_pkg::ALU_SUB, r_p, CapCalc};
                o_result  = '{!lt, '0, bhal_pkg::ST_OOM};
            end
            bhal_pkg::S_A_APP2: begin
                o_alu_req   = '{bhal_pkg::ALU_ADD1, r_p, '0};
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_p[ADDR_W-1:0];
                o_mem_wdata = sz_tag;
            end
            bhal_pkg::S_A_APP3: begin
                o_alu_req   = '{bhal_pkg::ALU_ADD1, top_c, '0};
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_top[ADDR_W-1:0];
                o_mem_wdata = sz_tag;
                o_result    = '{1'b1, {res[bhal_pkg::AddrW-3:0], 2'b00}, bhal_pkg::ST_DONE};
            end
            bhal_pkg::S_F_INIT: o_alu_req = '{bhal_pkg::ALU_SUB, r_h, CW'(1)};
            bhal_pkg::S_F_EQ:   o_alu_req = '{bhal_pkg::ALU_SUB, r_cur, r_h};
            bhal_pkg::S_F_BEG:  o_alu_req = '{bhal_pkg::ALU_ADD1, r_h, bsw};
            bhal_pkg::S_F_PV0:  o_alu_req = '{bhal_pkg::ALU_SUB, r_h, CW'(1)};
            bhal_pkg::S_F_PV1, bhal_pkg::S_F_NX2: begin
                o_mem_rd   = 1'b1;
                o_mem_addr = r_p[ADDR_W-1:0];
            end
            bhal_pkg::S_F_PV2:  o_alu_req = '{bhal_pkg::ALU_SUB, r_h, bsw};
            bhal_pkg::S_F_PV3:  o_alu_req = '{bhal_pkg::ALU_SUB, r_q, CW'(2)};
            bhal_pkg::S_F_PV4, bhal_pkg::S_F_NX6:
                o_alu_req = '{bhal_pkg::ALU_ADD, r_size, bs};
            bhal_pkg::S_F_PV5, bhal_pkg::S_F_NX7:
                o_alu_req = '{bhal_pkg::ALU_ADD, r_size, CW'(8)};
            bhal_pkg::S_F_NX0:  o_alu_req = '{bhal_pkg::ALU_ADD1, r_end, '0};
            bhal_pkg::S_F_NX1:  o_alu_req = '{bhal_pkg::ALU_SUB, r_p, top_c};
            bhal_pkg::S_F_NX3:  o_alu_req = '{bhal_pkg::ALU_ADD1, r_p, '0};
            bhal_pkg::S_F_NX4:  o_alu_req = '{bhal_pkg::ALU_ADD, r_q, bsw};
            bhal_pkg::S_F_NX5:  o_alu_req = '{bhal_pkg::ALU_SUB, r_q, top_c};
            bhal_pkg::S_F_WR0: begin
                o_alu_req   = '{bhal_pkg::ALU_ADD1, r_end, '0};
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_start[ADDR_W-1:0];
                o_mem_wdata = {r_size[TW-1:2], 2'b00};
            end
            bhal_pkg::S_F_WR1: begin
                o_alu_req   = '{bhal_pkg::ALU_SUB, r_p, top_c};
                o_mem_wr    = 1'b1;
                o_mem_addr  = r_end[ADDR_W-1:0];
                o_mem_wdata = {r_size[TW-1:2], 2'b00};
                o_result    = '{1'b1, '0, bhal_pkg::ST_DONE};
            end
            bhal_pkg::S_F_IGN:  o_result = '{1'b1, '0, bhal_pkg::ST_IGNORED};
            default: begin
            end
        endcase
    end

    // Control state: sequencer state and heap top (in words).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhal_pkg::S_IDLE;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == bhal_pkg::S_A_APP3) begin
                r_top <= r_nxt[TOP_W-1:0];
            end
            // A freed block that reaches the top lowers the top to its start.
            if (r_state == bhal_pkg::S_F_WR1 && !lt) begin
                r_top <= r_start[TOP_W-1:0];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bhal_pkg::S_IDLE: begin
                r_sz  <= CW'(i_alloc_size);
                r_h   <= CW'(i_free_addr[bhal_pkg::AddrW-1:2]);
                r_bad <= (i_free_addr[1:0] != 2'b00) ||
                         (i_free_addr[bhal_pkg::AddrW-1:2] == '0);
                r_cur <= '0;
            end
            bhal_pkg::S_A_INIT: r_sz <= {res[CW-1:2], 2'b00};
            bhal_pkg::S_A_TAG, bhal_pkg::S_A_NXT, bhal_pkg::S_F_TAG, bhal_pkg::S_F_NXT:
                r_nxt <= res;
            bhal_pkg::S_A_CMP: begin
                if (!lt && used) begin
                    r_cur <= r_nxt;
                end
            end
            bhal_pkg::S_A_FIT: begin
                if (lt) begin
                    r_cur <= r_nxt;
                end
                r_left <= res;
            end
            bhal_pkg::S_A_SP0, bhal_pkg::S_A_SP1, bhal_pkg::S_A_SP3, bhal_pkg::S_A_WH0,
            bhal_pkg::S_A_APP0, bhal_pkg::S_F_PV0, bhal_pkg::S_F_NX0, bhal_pkg::S_F_WR0:
                r_p <= res;
            bhal_pkg::S_A_SP2:  r_left <= res;
            bhal_pkg::S_A_APP2: r_nxt <= res;
            bhal_pkg::S_F_INIT: r_h <= res;
            bhal_pkg::S_F_EQ: begin
                if (!zero && lt) begin
                    r_cur <= r_nxt;
                end
            end
            bhal_pkg::S_F_BEG: begin
                r_end   <= res;
                r_size  <= bs;
                r_start <= r_h;
            end
            bhal_pkg::S_F_PV2, bhal_pkg::S_F_NX3, bhal_pkg::S_F_NX4: r_q <= res;
            bhal_pkg::S_F_PV3: begin
                if (!lt) begin
                    r_start <= res;
                end
            end
            bhal_pkg::S_F_PV4, bhal_pkg::S_F_PV5, bhal_pkg::S_F_NX6, bhal_pkg::S_F_NX7:
                r_size <= res;
            bhal_pkg::S_F_NX5: begin
                if (lt && !used) begin
                    r_end <= r_q;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### test/boundary_tag_heap_allocator_core_test.sv
// Self-checking testbench for boundary_tag_heap_allocator_core: directed and random allocate
// and free requests, checked against a first-fit heap predictor. Depends on bhal_pkg.
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_core_test;

    localparam int unsigned HEAP_CAP =
        (bhal_pkg::HeapWordsDefault < bhal_pkg::CapLimit) ? bhal_pkg::HeapWordsDefault
                                                           : bhal_pkg::CapLimit;
    localparam int unsigned SIZE_BITS = 32'h0001_FFFC;
    localparam int unsigned HELD_MAX  = 30;
    localparam int unsigned PHASE_LEN = 172;

    typedef struct {
        logic [bhal_pkg::AddrW-1:0] addr;
        bhal_pkg::t_status          st;
        int unsigned                seq;
    } t_grant;

    typedef struct {
        logic              rtype;
        int unsigned       nbytes;
        int unsigned       faddr;
        bit                typed;
        int unsigned       exp_addr;
        bhal_pkg::t_status exp_st;
    } t_plan_row;

    logic                       i_clk;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic                       i_req_type   = bhal_pkg::REQ_ALLOC;
    logic [bhal_pkg::SizeW-1:0] i_alloc_size = '0;
    logic [bhal_pkg::AddrW-1:0] i_free_addr  = '0;
    logic                       o_strobe;
    logic [bhal_pkg::AddrW-1:0] o_payload_addr;
    logic [1:0]                 o_status;
    logic                       i_cfg_valid  = 1'b0;
    logic                       o_cfg_ready;
    logic [bhal_pkg::SizeW-1:0] i_cfg_data   = '0;

    // Predictor state: the heap tags, the heap end in bytes and the split threshold.
    bit [31:0]   heap_words [HEAP_CAP];
    int unsigned heap_end    = 0;
    int unsigned split_floor = bhal_pkg::MinSplitReset;

    t_grant      grant_queue [$];
    int unsigned held_addrs [$];
    int unsigned last_released = 0;
    int unsigned req_count     = 0;
    int          grant_errors  = 0;
    bit          no_gaps       = 0;
    t_plan_row   plan [25];

    boundary_tag_heap_allocator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_alloc_size   (i_alloc_size),
        .i_free_addr    (i_free_addr),
        .o_strobe       (o_strobe),
        .o_payload_addr (o_payload_addr),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned tag_at(int unsigned w);
        return (w < HEAP_CAP) ? heap_words[w] : 0;
    endfunction

    function automatic void put_tag(int unsigned w, int unsigned v);
        if (w < HEAP_CAP) heap_words[w] = v;
    endfunction

    function automatic void alloc_first_fit(input int unsigned want,
                                            output int unsigned addr,
                                            output bhal_pkg::t_status st);
        int unsigned sz, topw, thr, cur, tag, bs, nxt, left, f;
        sz   = (want + 3) & 32'hFFFF_FFFC;
        topw = heap_end >> 2;
        thr  = (split_floor < 8) ? 8 : split_floor;
        cur  = 0;
        while (cur < topw) begin
            tag = tag_at(cur);
            bs  = tag & SIZE_BITS;
            nxt = cur + 2 + bs / 4;
            if (nxt > topw) break;
            if ((tag & 1) == 0 && sz <= bs) begin
                left = bs - sz;
                if (left >= thr) begin
                    // Split: the used part keeps the front, the rest becomes a free block.
                    f = cur + 1 + sz / 4;
                    put_tag(cur, sz | 1);
                    put_tag(f, sz | 1);
                    put_tag(f + 1, left - 8);
                    put_tag(nxt - 1, left - 8);
                end else begin
                    put_tag(cur, bs | 1);
                    put_tag(nxt - 1, bs | 1);
                end
                addr = ((cur + 1) * 4) & 32'hFFFF;
                st   = bhal_pkg::ST_DONE;
                return;
            end
            cur = nxt;
        end
        if (sz / 4 + 2 > HEAP_CAP - topw) begin
            addr = 0;
            st   = bhal_pkg::ST_OOM;
            return;
        end
        put_tag(topw, sz | 1);
        put_tag(topw + 1 + sz / 4, sz | 1);
        heap_end = (topw + 2 + sz / 4) * 4;
        addr = ((topw + 1) * 4) & 32'hFFFF;
        st   = bhal_pkg::ST_DONE;
    endfunction

    function automatic void release_block(input int unsigned a,
                                          output bhal_pkg::t_status st);
        int unsigned topw, cur, h, tag, nbytes, first, last_w, nxt, pt, ps, nt, ns, nf;
        bit found;
        topw  = heap_end >> 2;
        st    = bhal_pkg::ST_IGNORED;
        found = 0;
        cur   = 0;
        if ((a & 3) != 0 || a < 4) return;
        h = a / 4 - 1;
        while (cur < topw) begin
            nxt = cur + 2 + (tag_at(cur) & SIZE_BITS) / 4;
            if (nxt > topw) break;
            if (cur == h) begin
                found = 1;
                break;
            end
            if (cur > h) break;
            cur = nxt;
        end
        if (!found) return;
        tag = tag_at(h);
        if ((tag & 1) == 0) return;

        nbytes = tag & SIZE_BITS;
        first  = h;
        last_w = h + 1 + nbytes / 4;
        if (h > 0) begin
            pt = tag_at(h - 1);
            ps = pt & SIZE_BITS;
            if ((pt & 1) == 0 && ps / 4 + 2 <= h) begin
                first  = h - 2 - ps / 4;
                nbytes += ps + 8;
            end
        end
        if (last_w + 1 < topw) begin
            nt = tag_at(last_w + 1);
            ns = nt & SIZE_BITS;
            nf = last_w + 2 + ns / 4;
            if ((nt & 1) == 0 && nf < topw) begin
                last_w = nf;
                nbytes += ns + 8;
            end
        end
        put_tag(first, nbytes & SIZE_BITS);
        put_tag(last_w, nbytes & SIZE_BITS);
        // The merged block is the last one, so the heap shrinks back to its start.
        if (last_w + 1 >= topw) heap_end = first * 4;
        st = bhal_pkg::ST_DONE;
    endfunction

    function automatic t_grant serve_request(logic rtype, int unsigned nbytes,
                                             int unsigned faddr);
        t_grant            g;
        int unsigned       a;
        bhal_pkg::t_status s;
        if (rtype == bhal_pkg::REQ_ALLOC) begin
            alloc_first_fit(nbytes & 32'h1FFFF, a, s);
        end else begin
            release_block(faddr & 32'hFFFF, s);
            a = 0;
        end
        g.addr = a[bhal_pkg::AddrW-1:0];
        g.st   = s;
        g.seq  = 0;
        return g;
    endfunction

    task automatic flag_grant(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        grant_errors++;
    endtask

    task automatic issue_request(input logic rtype, input int unsigned nbytes,
                                 input int unsigned faddr, input bit typed,
                                 input int unsigned t_addr, input bhal_pkg::t_status t_st);
        t_grant g;
        int     idx [$];
        start        <= 1'b1;
        i_req_type   <= rtype;
        i_alloc_size <= nbytes[bhal_pkg::SizeW-1:0];
        i_free_addr  <= faddr[bhal_pkg::AddrW-1:0];
        do @(posedge i_clk); while (busy);
        g = serve_request(rtype, nbytes, faddr);
        if (rtype == bhal_pkg::REQ_ALLOC && g.st == bhal_pkg::ST_DONE)
            held_addrs.push_back(g.addr);
        if (rtype == bhal_pkg::REQ_FREE && g.st == bhal_pkg::ST_DONE) begin
            idx = held_addrs.find_first_index with (item == (faddr & 32'hFFFF));
            if (idx.size() != 0) held_addrs.delete(idx[0]);
            last_released = faddr & 32'hFFFF;
        end
        if (typed) begin
            g.addr = t_addr[bhal_pkg::AddrW-1:0];
            g.st   = t_st;
        end
        g.seq = req_count;
        req_count++;
        grant_queue.push_back(g);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic hold_off(input int unsigned n);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every outstanding request come back.
    task automatic settle();
        start <= 1'b0;
        while (grant_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_split(input int unsigned v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[bhal_pkg::SizeW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        split_floor = v & 32'h1FFFF;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned random_alloc_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 64);
        if (r < 85) return $urandom_range(65, 600);
        if (r < 93) return $urandom_range(601, 8000);
        if (r < 97) return $urandom_range(0, 65536);
        return 65536 - $urandom_range(0, 16);
    endfunction

    task automatic random_request();
        int unsigned pick, nbytes, faddr, a;
        logic        rtype;
        pick   = $urandom_range(0, 99);
        nbytes = $urandom_range(0, 65536);
        faddr  = $urandom() & 32'hFFFF;
        if (pick >= 85) begin
            // Bad or doubtful frees: random address, double free, misaligned, interior.
            rtype = bhal_pkg::REQ_FREE;
            case ($urandom_range(0, 3))
                1: faddr = last_released;
                2: if (held_addrs.size() != 0) begin
                    a     = held_addrs[$urandom_range(0, held_addrs.size() - 1)];
                    faddr = (a + $urandom_range(1, 3)) & 32'hFFFF;
                end
                3: if (held_addrs.size() != 0) begin
                    a     = held_addrs[$urandom_range(0, held_addrs.size() - 1)];
                    faddr = (a + 4) & 32'hFFFF;
                end
                default: ;
            endcase
        end else if ((pick < 45 && held_addrs.size() < HELD_MAX) || held_addrs.size() == 0) begin
            rtype  = bhal_pkg::REQ_ALLOC;
            nbytes = random_alloc_size();
        end else begin
            rtype = bhal_pkg::REQ_FREE;
            faddr = held_addrs[$urandom_range(0, held_addrs.size() - 1)];
        end
        issue_request(rtype, nbytes, faddr, 1'b0, 0, bhal_pkg::ST_DONE);
    endtask

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_strobe) begin
            if (grant_queue.size() == 0) begin
                flag_grant($sformatf("result addr %0d status %0d with no request pending",
                                     o_payload_addr, o_status));
            end else begin
                g = grant_queue.pop_front();
                if (o_payload_addr !== g.addr)
                    flag_grant($sformatf("request %0d: payload_addr %0d, expected %0d",
                                         g.seq, o_payload_addr, g.addr));
                if (o_status !== g.st)
                    flag_grant($sformatf("request %0d: status %0d, expected %0d",
                                         g.seq, o_status, g.st));
            end
        end
    end

    initial begin
        int unsigned phase_split [8];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rows flagged typed carry their answer; the others go by the predictor.
        plan = '{
            '{bhal_pkg::REQ_FREE,  0,     0,     1, 0,     bhal_pkg::ST_IGNORED},
            '{bhal_pkg::REQ_ALLOC, 65536, 0,     1, 0,     bhal_pkg::ST_OOM},
            '{bhal_pkg::REQ_ALLOC, 0,     0,     1, 4,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     6,     1, 0,     bhal_pkg::ST_IGNORED},
            '{bhal_pkg::REQ_FREE,  0,     4,     1, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     4,     1, 0,     bhal_pkg::ST_IGNORED},
            '{bhal_pkg::REQ_FREE,  0,     65535, 1, 0,     bhal_pkg::ST_IGNORED},
            '{bhal_pkg::REQ_ALLOC, 65520, 0,     1, 4,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 0,     0,     1, 65532, bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 0,     0,     1, 0,     bhal_pkg::ST_OOM},
            '{bhal_pkg::REQ_FREE,  0,     65532, 1, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     4,     1, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 100,   0,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 1,     0,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 40,    0,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 8,     0,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     4,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 40,    0,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_ALLOC, 30,    0,     0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     112,   0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     52,    0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     124,   0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     124,   0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     172,   0, 0,     bhal_pkg::ST_DONE},
            '{bhal_pkg::REQ_FREE,  0,     4,     0, 0,     bhal_pkg::ST_DONE}
        };
        // In order: free on an empty heap, larger than the whole heap, empty payload,
        // misaligned, free it, above the heap end, misaligned at the top, all but two
        // words, filling the heap exactly, full heap, then emptying it again. The
        // predicted rows build four blocks, split a freed block, take a whole
        // remainder, merge with the next and the previous block, free an address that
        // is no longer a block start, and shrink the heap from its last block.
        foreach (plan[i]) begin
            issue_request(plan[i].rtype, plan[i].nbytes, plan[i].faddr, plan[i].typed,
                          plan[i].exp_addr, plan[i].exp_st);
            hold_off(pick_gap());
        end

        phase_split = '{65536, 8, 0, 65535, 48, $urandom_range(8, 256),
                        $urandom_range(9, 1024), 32};
        for (int p = 0; p < 8; p++) begin
            settle();
            write_min_split(phase_split[p]);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
                if ($urandom_range(0, 149) == 0) settle();
                random_request();
                hold_off(pick_gap());
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (grant_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
